### hw/rtl/pdwr_pkg.sv
package pdwr_pkg;

	localparam int NUM_DOMAINS_DEF = 9;
	localparam int COUNT_BITS_DEF  = 8;

	localparam int MASK_W    = 9;
	localparam int OFFSET_W  = 21;
	localparam int ACTION_W  = 2;
	localparam int GEN_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DW    = 9;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_GET    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_ACCESS = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GENERATION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENT    = 1'b1;

	localparam logic [GEN_W-1:0]  GENERATION_RST = 4'd9;
	localparam logic [MASK_W-1:0] PRESENT_RST    = 9'd7;

	localparam logic [GEN_W-1:0] GEN_SINGLE     = 4'd8;
	localparam logic [GEN_W-1:0] GEN_PER_ENGINE = 4'd11;

	// domain bits
	localparam logic [MASK_W-1:0] D_NONE   = 9'h000;
	localparam logic [MASK_W-1:0] D_RENDER = 9'h001;
	localparam logic [MASK_W-1:0] D_GT     = 9'h002;
	localparam logic [MASK_W-1:0] D_MEDIA  = 9'h004;
	localparam logic [MASK_W-1:0] D_VD0    = 9'h008;
	localparam logic [MASK_W-1:0] D_VD1    = 9'h010;
	localparam logic [MASK_W-1:0] D_VD2    = 9'h020;
	localparam logic [MASK_W-1:0] D_VD3    = 9'h040;
	localparam logic [MASK_W-1:0] D_VE0    = 9'h080;
	localparam logic [MASK_W-1:0] D_VE1    = 9'h100;

	typedef struct packed {
		logic capture;  // latch the accepted request
		logic commit;   // update counts and load the result register
	} pdwr_cmd_t;

	function automatic logic in_rng(
		input logic [OFFSET_W-1:0] r,
		input logic [OFFSET_W-1:0] lo,
		input logic [OFFSET_W-1:0] hi
	);
		return (r >= lo) && (r < hi);
	endfunction

	// Range map: first match wins; unmapped offsets select all present domains.
	function automatic logic [MASK_W-1:0] decode_offset(
		input logic [GEN_W-1:0]    gen,
		input logic [OFFSET_W-1:0] r,
		input logic [MASK_W-1:0]   present
	);
		logic per_engine;
		per_engine = (gen >= GEN_PER_ENGINE);
		if (in_rng(r, 21'h040000, 21'h100000)) return D_NONE;
		if (in_rng(r, 21'h0c0000, 21'h0e0000)) return D_NONE;
		if (in_rng(r, 21'h101000, 21'h102000)) return D_NONE;
		if (gen == GEN_SINGLE) return D_RENDER;
		if (per_engine) begin
			if (in_rng(r, 21'h1c0000, 21'h1c4000)) return D_VD0;
			if (in_rng(r, 21'h1c4000, 21'h1c8000)) return D_VD1;
			if (in_rng(r, 21'h1c8000, 21'h1cc000)) return D_VE0;
			if (in_rng(r, 21'h1d0000, 21'h1d4000)) return D_VD2;
			if (in_rng(r, 21'h1d4000, 21'h1d8000)) return D_VD3;
			if (in_rng(r, 21'h1d8000, 21'h1dc000)) return D_VE1;
			if (in_rng(r, 21'h190000, 21'h1a0000)) return D_NONE;
		end
		if (in_rng(r, 21'h002000, 21'h004000)) return D_RENDER;
		if (in_rng(r, 21'h004000, 21'h005000)) return D_GT;
		if (in_rng(r, 21'h005000, 21'h008000)) return D_RENDER;
		if (in_rng(r, 21'h008000, 21'h008300)) return D_GT;
		if (in_rng(r, 21'h008300, 21'h008500)) return D_RENDER;
		if (in_rng(r, 21'h008500, 21'h00b000)) return D_GT;
		if (in_rng(r, 21'h00b000, 21'h00b480)) return D_RENDER;
		if (in_rng(r, 21'h00b480, 21'h00d000)) return D_GT;
		if (in_rng(r, 21'h00d000, 21'h00d800)) return D_NONE;
		if (in_rng(r, 21'h00d800, 21'h00e000)) return D_GT;
		if (in_rng(r, 21'h00e000, 21'h012000)) return D_RENDER;
		if (!per_engine && in_rng(r, 21'h012000, 21'h014000)) return D_MEDIA;
		if (in_rng(r, 21'h014000, 21'h01a000)) return D_GT;
		if (!per_engine && in_rng(r, 21'h01a000, 21'h01c000)) return D_MEDIA;
		if (in_rng(r, 21'h01c000, 21'h040000)) return D_GT;
		return present;
	endfunction

endpackage

### hw/rtl/pdwr_if.sv
interface pdwr_req_if;
	import pdwr_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [MASK_W-1:0]   domain_mask;
	logic [OFFSET_W-1:0] reg_offset;

	modport source (output valid, action, domain_mask, reg_offset, input ready);
	modport sink   (input valid, action, domain_mask, reg_offset, output ready);
endinterface

interface pdwr_rsp_if;
	import pdwr_pkg::*;
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] domains;
	logic [MASK_W-1:0] woken;
	logic [MASK_W-1:0] released;
	logic [MASK_W-1:0] held;
	logic              saturated;

	modport source (output valid, domains, woken, released, held, saturated, input ready);
	modport sink   (input valid, domains, woken, released, held, saturated, output ready);
endinterface

### hw/rtl/power_domain_wake_refcounter_core.sv
// A request beat is taken into the request registers while the controller is idle;
// its response beat is loaded into the response register once that register is free.
// A new request beat is not taken until the current one is committed; the
// capture/compute handshake of the controller sets this, and a stalled
// response holds the compute step. Reset: arst_n clears all counts, sets
// generation to 9 and present domains to 0x007, and empties the response register.
module power_domain_wake_refcounter_core import pdwr_pkg::*; #(
	parameter int NUM_DOMAINS = NUM_DOMAINS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DW-1:0]    cfg_wdata,
	pdwr_req_if.sink             req,
	pdwr_rsp_if.source           rsp
);

	pdwr_cmd_t cmd;

	// Controller: takes a request beat while idle, then commits it once the
	// response register can take the result.
	pdwr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// Datapath: config registers, per-domain reference counters, offset
	// decode and the response register.
	pdwr_dpath #(
		.NUM_DOMAINS (NUM_DOMAINS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_wdata     (cfg_wdata),
		.in_action     (req.action),
		.in_mask       (req.domain_mask),
		.in_offset     (req.reg_offset),
		.out_domains   (rsp.domains),
		.out_woken     (rsp.woken),
		.out_released  (rsp.released),
		.out_held      (rsp.held),
		.out_saturated (rsp.saturated)
	);

endmodule

### hw/rtl/pdwr_ctrl.sv
module pdwr_ctrl import pdwr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pdwr_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic state_q;
	logic out_valid_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.capture = in_valid && in_ready;
	// commit only when the result register is free or drains this cycle
	assign cmd.commit  = (state_q == ST_CALC) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd.capture) state_q <= ST_CALC;
				ST_CALC: if (cmd.commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/pdwr_dpath.sv
module pdwr_dpath import pdwr_pkg::*; #(
	parameter int NUM_DOMAINS = NUM_DOMAINS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pdwr_cmd_t            cmd,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DW-1:0]    cfg_wdata,
	input  logic [ACTION_W-1:0]  in_action,
	input  logic [MASK_W-1:0]    in_mask,
	input  logic [OFFSET_W-1:0]  in_offset,
	output logic [MASK_W-1:0]    out_domains,
	output logic [MASK_W-1:0]    out_woken,
	output logic [MASK_W-1:0]    out_released,
	output logic [MASK_W-1:0]    out_held,
	output logic                 out_saturated
);

	// only the domains that fit the mask fields can ever be addressed
	localparam int DU = (NUM_DOMAINS < MASK_W) ? NUM_DOMAINS : MASK_W;
	localparam logic [MASK_W-1:0] DOM_ALL = MASK_W'((32'd1 << DU) - 32'd1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic [ACTION_W-1:0]   action_q;
	logic [MASK_W-1:0]     mask_q;
	logic [OFFSET_W-1:0]   offset_q;
	logic [GEN_W-1:0]      gen_q;
	logic [MASK_W-1:0]     present_q;
	logic [COUNT_BITS-1:0] count_q [DU];
	logic [COUNT_BITS-1:0] count_d [DU];

	logic [MASK_W-1:0] dom_sel;
	logic [MASK_W-1:0] dom;
	logic [MASK_W-1:0] woken;
	logic [MASK_W-1:0] released;
	logic [MASK_W-1:0] held;
	logic              sat;

	function automatic logic in_action_sel(input logic [ACTION_W-1:0] a);
		return (a == ACT_GET) || (a == ACT_PUT);
	endfunction

	always_comb begin
		case (in_action_sel(action_q))
			1'b1: dom_sel = mask_q;
			default: dom_sel = (action_q == ACT_ACCESS) ?
				decode_offset(gen_q, offset_q, present_q) : D_NONE;
		endcase
		dom      = dom_sel & present_q & DOM_ALL;
		woken    = '0;
		released = '0;
		held     = '0;
		sat      = 1'b0;
		for (int i = 0; i < DU; i++) begin
			count_d[i] = count_q[i];
			if (dom[i]) begin
				case (action_q)
					ACT_GET: begin
						if (count_q[i] == '0) woken[i] = 1'b1;
						if (count_q[i] == CNT_MAX) sat = 1'b1;
						else count_d[i] = count_q[i] + 1'b1;
					end
					ACT_PUT: begin
						if (count_q[i] != '0) begin
							count_d[i] = count_q[i] - 1'b1;
							if (count_q[i] == COUNT_BITS'(1)) released[i] = 1'b1;
						end
					end
					ACT_ACCESS: begin
						if (count_q[i] == '0) begin
							woken[i]    = 1'b1;
							released[i] = 1'b1;
						end
						if (count_q[i] == CNT_MAX) sat = 1'b1;
					end
					default: count_d[i] = count_q[i];
				endcase
			end
			held[i] = (count_d[i] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			mask_q   <= in_mask;
			offset_q <= in_offset;
		end
		if (cmd.commit) begin
			out_domains   <= dom;
			out_woken     <= woken;
			out_released  <= released;
			out_held      <= held;
			out_saturated <= sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q     <= GENERATION_RST;
			present_q <= PRESENT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GENERATION: gen_q     <= cfg_wdata[GEN_W-1:0];
				REG_PRESENT:    present_q <= cfg_wdata[MASK_W-1:0];
				default:        gen_q     <= gen_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DU; i++) count_q[i] <= '0;
		end else if (cmd.commit) begin
			for (int i = 0; i < DU; i++) count_q[i] <= count_d[i];
		end
	end

endmodule

### hw/rtl/pdwr_chk.sv
module pdwr_chk import pdwr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [MASK_W-1:0] rsp_domains,
	input logic [MASK_W-1:0] rsp_woken,
	input logic [MASK_W-1:0] rsp_released,
	input logic [MASK_W-1:0] rsp_held
);

	// a stalled response beat keeps its held and domains fields
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_held) && $stable(rsp_domains))
		else $error("response changed while stalled");

	a_woken_in_domains: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_woken & ~rsp_domains) == '0)
		else $error("woken domain outside effective mask");

	a_released_not_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_released & rsp_held) == '0)
		else $error("released domain still held");

	a_rsp_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a matching request");

endmodule

bind power_domain_wake_refcounter_core pdwr_chk u_pdwr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_domains  (rsp.domains),
	.rsp_woken    (rsp.woken),
	.rsp_released (rsp.released),
	.rsp_held     (rsp.held)
);
